@@ hdl/pttt_pkg.sv @@
`default_nettype none
package pttt_pkg;

  // field widths
  localparam int MODE_W    = 3;
  localparam int SLOT_W    = 4;
  localparam int HANDLE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int MAX_OUT   = 16;
  localparam int FOUND_W   = 5;

  // slow path threshold after reset
  localparam logic [TIME_W-1:0] SLOW_RESET = 32'd8000;

  // request modes
  typedef enum logic [MODE_W-1:0] {
    OP_REG   = 3'd0,
    OP_ADJ   = 3'd1,
    OP_UNREG = 3'd2,
    OP_PULL  = 3'd3,
    OP_TICK  = 3'd4,
    OP_COMPL = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEFER = 2'd2,
    ST_DUE   = 2'd3
  } status_t;

  // input request
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] task_handle;
    logic [TIME_W-1:0]   run_period;
    logic [TIME_W-1:0]   now_us;
    logic [KIND_W-1:0]   callback_kind;
    logic                uses_lock;
    logic                success;
  } in_req_t;

  // result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [KIND_W-1:0]   kind_out;
    logic                lock_out;
    logic                last;
  } res_t;

  // one table slot
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   last_start;
    logic [KIND_W-1:0]   kind;
    logic                lock;
  } slot_rec_t;

  // source of the result register
  typedef enum logic [2:0] {
    LD_ZERO      = 3'd0,
    LD_OOR       = 3'd1,
    LD_DEFER     = 3'd2,
    LD_FULL      = 3'd3,
    LD_SLOT      = 3'd4,
    LD_PEND      = 3'd5,
    LD_PEND_LAST = 3'd6
  } ld_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    load_slot;
    logic    rd_en;
    logic    idx_inc;
    logic    wr_en;
    logic    used_inc;
    logic    pend_cap;
    logic    out_load;
    ld_sel_t out_sel;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              over_thr;
    logic              slot_ok;
    logic              scan_end;
    logic              hit;
    logic              pend_v;
    logic              out_free;
    logic              full;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/pttt_dp.sv @@
`default_nettype none
module pttt_dp import pttt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [TIME_W-1:0]  cfg_wdata,
  input  wire in_req_t            in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output res_t                    out_data,
  input  wire ctl_cmd_t           cmd,
  output dp_stat_t                st
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int UW = $clog2(SLOTS + 1);

  logic [TIME_W-1:0]  thr;
  in_req_t            req;
  logic [UW-1:0]      idx;
  logic [UW-1:0]      used;
  logic [FOUND_W-1:0] found;
  res_t               pend;
  logic               pend_v;
  logic [SLOTS-1:0]   valid;
  slot_rec_t          mem [SLOTS];
  slot_rec_t          rd_raw;
  logic               rd_vld;
  res_t               out_r;
  logic               out_v;

  logic [IW-1:0]      idx_lo;
  slot_rec_t          rd_rec;
  slot_rec_t          mod_rec;
  logic [TIME_W-1:0]  age;
  logic               hit;
  res_t               res_next;
  res_t               pend_next;

  assign idx_lo = idx[IW-1:0];
  // entries never written read as zero
  assign rd_rec = rd_vld ? rd_raw : '0;
  assign age    = req.now_us - rd_rec.last_start;

  // match or due test on the slot just read
  always_comb begin
    hit = 1'b0;
    case (req.mode)
      OP_REG:  hit = (rd_rec.handle == '0) || (rd_rec.handle == req.task_handle);
      OP_PULL: hit = (rd_rec.handle == req.task_handle);
      OP_TICK: hit = (rd_rec.handle != '0) && (age > rd_rec.period);
      default: hit = 1'b0;
    endcase
  end

  // slot contents after the action
  always_comb begin
    mod_rec = rd_rec;
    case (req.mode)
      OP_REG: begin
        mod_rec.handle     = req.task_handle;
        mod_rec.period     = req.run_period;
        mod_rec.last_start = req.now_us;
        mod_rec.kind       = req.callback_kind;
        mod_rec.lock       = req.uses_lock;
      end
      OP_ADJ:   mod_rec.period = req.run_period;
      OP_UNREG: mod_rec.handle = '0;
      OP_PULL:  mod_rec.last_start = rd_rec.last_start - rd_rec.period;
      OP_COMPL: begin
        if (req.success) begin
          mod_rec.last_start = rd_rec.last_start + rd_rec.period;
        end
      end
      default: mod_rec = rd_rec;
    endcase
  end

  // due entry held back until the next one or the scan end
  always_comb begin
    pend_next            = '0;
    pend_next.status     = ST_DUE;
    pend_next.slot_out   = SLOT_W'(idx);
    pend_next.handle_out = rd_rec.handle;
    pend_next.kind_out   = rd_rec.kind;
    pend_next.lock_out   = rd_rec.lock;
    pend_next.last       = 1'b0;
  end

  // result select
  always_comb begin
    res_next        = '0;
    res_next.status = ST_DONE;
    res_next.last   = 1'b1;
    case (cmd.out_sel)
      LD_ZERO: res_next.status = ST_DONE;
      LD_OOR:  res_next.slot_out = req.slot;
      LD_DEFER, LD_FULL: begin
        res_next.status     = (cmd.out_sel == LD_DEFER) ? ST_DEFER : ST_FULL;
        res_next.handle_out = req.task_handle;
        res_next.kind_out   = req.callback_kind;
        res_next.lock_out   = req.uses_lock;
      end
      LD_SLOT: begin
        res_next.slot_out   = SLOT_W'(idx);
        res_next.handle_out = mod_rec.handle;
        res_next.kind_out   = mod_rec.kind;
        res_next.lock_out   = mod_rec.lock;
      end
      LD_PEND: begin
        res_next      = pend;
        res_next.last = 1'b0;
      end
      LD_PEND_LAST: begin
        res_next      = pend;
        res_next.last = 1'b1;
      end
      default: res_next.status = ST_DONE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= SLOW_RESET;
      used   <= '0;
      valid  <= '0;
      pend_v <= 1'b0;
      found  <= '0;
      out_v  <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (cmd.used_inc) begin
        used <= used + UW'(1);
      end
      if (cmd.wr_en) begin
        valid[idx_lo] <= 1'b1;
      end
      if (cmd.accept) begin
        pend_v <= 1'b0;
        found  <= '0;
      end else if (cmd.pend_cap) begin
        pend_v <= 1'b1;
        found  <= found + FOUND_W'(1);
      end
      if (cmd.out_load) begin
        out_v <= 1'b1;
      end else if (out_ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req <= in_data;
    end
    if (cmd.accept) begin
      idx <= '0;
    end else if (cmd.load_slot) begin
      idx <= UW'(req.slot);
    end else if (cmd.idx_inc) begin
      idx <= idx + UW'(1);
    end
    if (cmd.pend_cap) begin
      pend <= pend_next;
    end
    if (cmd.out_load) begin
      out_r <= res_next;
    end
  end

  // slot memory, one port, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx_lo] <= mod_rec;
    end
    if (cmd.rd_en) begin
      rd_raw <= mem[idx_lo];
      rd_vld <= valid[idx_lo];
    end
  end

  // status to the controller
  always_comb begin
    st          = '0;
    st.mode     = req.mode;
    st.over_thr = req.run_period > thr;
    st.slot_ok  = 32'(req.slot) < SLOTS;
    st.scan_end = (idx >= used) || (found == FOUND_W'(MAX_OUT));
    st.hit      = hit;
    st.pend_v   = pend_v;
    st.out_free = !out_v || out_ready;
    st.full     = used >= UW'(SLOTS);
  end

  assign out_valid = out_v;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ hdl/pttt_ctrl.sv @@
`default_nettype none
module pttt_ctrl import pttt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t st,
  output ctl_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_READ     = 7'b0000100,
    S_SCAN_RD  = 7'b0001000,
    S_SCAN_EV  = 7'b0010000,
    S_FINISH   = 7'b0100000,
    S_WRITE    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of one request
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_sel = LD_ZERO;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.mode)
          OP_REG: begin
            if (!st.over_thr) begin
              state_next = S_SCAN_RD;
            end else if (st.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = LD_DEFER;
              state_next   = S_IDLE;
            end
          end
          OP_ADJ, OP_UNREG, OP_COMPL: begin
            if (st.slot_ok) begin
              cmd.load_slot = 1'b1;
              state_next    = S_READ;
            end else if (st.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = LD_OOR;
              state_next   = S_IDLE;
            end
          end
          OP_PULL, OP_TICK: state_next = S_SCAN_RD;
          default: begin
            if (st.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = LD_ZERO;
              state_next   = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_WRITE;
      end
      S_SCAN_RD: begin
        if (st.scan_end) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (st.mode == OP_TICK) begin
          // a new due slot pushes the held one out
          if (!st.hit) begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SCAN_RD;
          end else if (!st.pend_v || st.out_free) begin
            cmd.out_load = st.pend_v;
            cmd.out_sel  = LD_PEND;
            cmd.pend_cap = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_next   = S_SCAN_RD;
          end
        end else if (st.hit) begin
          state_next = S_WRITE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_FINISH: begin
        case (st.mode)
          OP_REG: begin
            if (!st.full) begin
              cmd.used_inc = 1'b1;
              state_next   = S_WRITE;
            end else if (st.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = LD_FULL;
              state_next   = S_IDLE;
            end
          end
          OP_TICK: begin
            if (st.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = st.pend_v ? LD_PEND_LAST : LD_ZERO;
              state_next   = S_IDLE;
            end
          end
          default: begin
            if (st.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = LD_ZERO;
              state_next   = S_IDLE;
            end
          end
        endcase
      end
      S_WRITE: begin
        if (st.out_free) begin
          cmd.wr_en    = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_sel  = LD_SLOT;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/periodic_task_timer_table_unit.sv @@
`default_nettype none
// Periodic task timer table: up to SLOTS task slots with period, last run,
// callback kind and lock flag.
// Request channel in_valid/in_ready/in_data carries register, adjust,
// unregister, pull forward, tick and completion requests; one request is
// worked on at a time. Result channel out_valid/out_ready/out_data gives
// one result per request, or for a tick one per due slot, at most MAX_OUT,
// or a single one if none is due; the final one is flagged with last.
// cfg_we/cfg_wdata write the slow path threshold. A deferred register,
// an out of range slot or an unknown mode is answered from dispatch;
// adjust, unregister and completion read and then write their slot;
// register, pull forward and tick scan the used slots one at a time
// through the single memory port.
// A new request is taken in the cycle after the previous one's last result
// is loaded, even while that result still waits in the output register.
// A stalled receiver holds the scan at the next result to be loaded.
// Reset empties the table and sets the threshold to 8000 us.
module periodic_task_timer_table_unit import pttt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_req_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output res_t                   out_data
);

  ctl_cmd_t cmd;
  dp_stat_t st;

  // sequencer
  pttt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // slot table and result register
  pttt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

  // a result is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result register overwritten");

  // appending only while room remains
  a_used_room: assert property (@(posedge clk) disable iff (rst)
    cmd.used_inc |-> !st.full)
    else $error("slot count past table size");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // every slot write reports its result
  a_wr_res: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> cmd.out_load && (cmd.out_sel == LD_SLOT))
    else $error("slot written without result");

endmodule
`default_nettype wire
